// ===== hw/rtl/cbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPU busy percent averager package
// Field widths, command and result beats, and the back end state encoding.
// ----------------------------------------------------------------------------
package cbpa_pkg;

    localparam int CNT_W   = 63;   // cumulative tick counters
    localparam int TIME_W  = 32;   // millisecond time stamp
    localparam int CFG_W   = 16;   // minimum interval register
    localparam int DELTA_W = 64;   // signed counter delta
    localparam int SUM_W   = 65;   // user + kernel delta
    localparam int NUM_W   = 66;   // user + kernel - idle delta
    localparam int MAG_W   = 64;   // magnitudes once below the denominator
    localparam int PCT_W   = 7;    // percent value
    localparam int QBITS   = 7;    // quotient bits of the percent divide
    localparam int PROD_W  = MAG_W + QBITS;   // 100 * numerator

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd200;
    localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;

    typedef enum logic [1:0] {
        CMD_REPEAT,
        CMD_BASELINE,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 first;
        logic [DELTA_W-1:0]   du;
        logic [DELTA_W-1:0]   dk;
        logic [DELTA_W-1:0]   di;
    } cmd_t;

    typedef struct packed {
        logic [PCT_W-1:0] usage;
        logic             updated;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SUM,
        BK_NUM,
        BK_ABS,
        BK_CLASS,
        BK_MUL1,
        BK_MUL2,
        BK_DIV,
        BK_STORE,
        BK_ACC,
        BK_AVG,
        BK_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/cbpa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module cbpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/cbpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Busy averager front end
// Holds the interval register, decides whether a sample is taken, keeps the
// counter baselines and hands signed counter deltas to the back end.
// ----------------------------------------------------------------------------
module cbpa_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cbpa_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        push,
    input  logic                        cmd_full,
    input  logic [cbpa_pkg::CNT_W-1:0]  idle_ticks,
    input  logic [cbpa_pkg::CNT_W-1:0]  kernel_ticks,
    input  logic [cbpa_pkg::CNT_W-1:0]  user_ticks,
    input  logic [cbpa_pkg::TIME_W-1:0] now_ms,
    output logic                        cmd_push,
    output cbpa_pkg::cmd_t              cmd
);

    logic [cbpa_pkg::CFG_W-1:0]  min_interval_reg;
    logic                        first_reg;
    logic                        baseline_reg;
    logic [cbpa_pkg::TIME_W-1:0] mark_reg;
    logic [cbpa_pkg::CNT_W-1:0]  prev_idle_reg;
    logic [cbpa_pkg::CNT_W-1:0]  prev_kernel_reg;
    logic [cbpa_pkg::CNT_W-1:0]  prev_user_reg;
    logic [cbpa_pkg::TIME_W-1:0] elapsed;
    logic                        taken;

    assign cfg_ready = 1'b1;
    assign cmd_push  = push && !cmd_full;

    // The elapsed time wraps with the time stamp.
    assign elapsed = now_ms - mark_reg;
    assign taken   = elapsed > cbpa_pkg::TIME_W'(min_interval_reg);

    always_comb
    begin
        cmd.first = first_reg;
        if (!taken)
        begin
            cmd.kind = cbpa_pkg::CMD_REPEAT;
        end
        else if (!baseline_reg)
        begin
            cmd.kind = cbpa_pkg::CMD_BASELINE;
        end
        else
        begin
            cmd.kind = cbpa_pkg::CMD_COMPUTE;
        end
        cmd.du = {1'b0, user_ticks} - {1'b0, prev_user_reg};
        cmd.dk = {1'b0, kernel_ticks} - {1'b0, prev_kernel_reg};
        cmd.di = {1'b0, idle_ticks} - {1'b0, prev_idle_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= cbpa_pkg::MIN_INTERVAL_RST;
            first_reg        <= 1'b1;
            baseline_reg     <= 1'b0;
            mark_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_interval_reg <= cfg_data;
            end
            if (cmd_push)
            begin
                first_reg <= 1'b0;
                if (taken)
                begin
                    baseline_reg <= 1'b1;
                    mark_reg     <= now_ms;
                end
            end
        end
    end

    // Baselines are only read once the first sample has been taken.
    always_ff @(posedge clk)
    begin
        if (cmd_push && taken)
        begin
            prev_idle_reg   <= idle_ticks;
            prev_kernel_reg <= kernel_ticks;
            prev_user_reg   <= user_ticks;
        end
    end

endmodule

// ===== hw/rtl/cbpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Busy averager back end
// Turns counter deltas into a busy percent with a bit-serial divide, keeps
// the ring of recent percents and averages it with a second serial divide.
// ----------------------------------------------------------------------------
module cbpa_back #(
    parameter int WINDOW = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  cbpa_pkg::cmd_t   cmd_in,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output cbpa_pkg::result_t res_out
);

    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int TOT_W     = $clog2(100 * WINDOW + 1);
    localparam int AVG_CNT_W = $clog2(TOT_W);

    cbpa_pkg::back_state_t state_reg;
    cbpa_pkg::back_state_t state_next;

    cbpa_pkg::cmd_t                 cmd_reg;
    logic signed [cbpa_pkg::SUM_W-1:0] sum_reg;
    logic signed [cbpa_pkg::NUM_W-1:0] num_reg;
    logic [cbpa_pkg::NUM_W-1:0]     an_reg;
    logic [cbpa_pkg::SUM_W-1:0]     ad_reg;
    logic                           trivial_reg;
    logic [cbpa_pkg::PROD_W-1:0]    rem_reg;
    logic [cbpa_pkg::PROD_W-1:0]    dsh_reg;
    logic [2:0]                     div_cnt_reg;
    logic [cbpa_pkg::PCT_W-1:0]     pct_reg;
    logic [cbpa_pkg::PCT_W-1:0]     ring_reg [WINDOW];
    logic [PTR_W-1:0]               ptr_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic [PTR_W-1:0]               idx_reg;
    logic [TOT_W-1:0]               tot_reg;
    logic [FILL_W-1:0]              arem_reg;
    logic [AVG_CNT_W-1:0]           avg_cnt_reg;
    logic [cbpa_pkg::PCT_W-1:0]     last_usage_reg;

    logic                           div_ge;
    logic                           acc_done;
    logic [FILL_W:0]                avg_trial;
    logic                           avg_ge;
    logic                           avg_done;
    logic                           saturate;

    assign div_ge    = rem_reg >= dsh_reg;
    assign acc_done  = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;
    assign avg_trial = {arem_reg, tot_reg[TOT_W-1]};
    assign avg_ge    = avg_trial >= {1'b0, fill_reg};
    assign avg_done  = avg_cnt_reg == AVG_CNT_W'(TOT_W - 1);
    assign saturate  = an_reg >= {1'b0, ad_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbpa_pkg::BK_IDLE:
            begin
                if (cmd_pop)
                begin
                    state_next = (cmd_in.kind == cbpa_pkg::CMD_COMPUTE) ?
                                 cbpa_pkg::BK_SUM : cbpa_pkg::BK_EMIT;
                end
            end
            cbpa_pkg::BK_SUM:   state_next = cbpa_pkg::BK_NUM;
            cbpa_pkg::BK_NUM:   state_next = cbpa_pkg::BK_ABS;
            cbpa_pkg::BK_ABS:   state_next = cbpa_pkg::BK_CLASS;
            cbpa_pkg::BK_CLASS:
            begin
                state_next = (trivial_reg || saturate) ?
                             cbpa_pkg::BK_STORE : cbpa_pkg::BK_MUL1;
            end
            cbpa_pkg::BK_MUL1:  state_next = cbpa_pkg::BK_MUL2;
            cbpa_pkg::BK_MUL2:  state_next = cbpa_pkg::BK_DIV;
            cbpa_pkg::BK_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = cbpa_pkg::BK_STORE;
                end
            end
            cbpa_pkg::BK_STORE: state_next = cbpa_pkg::BK_ACC;
            cbpa_pkg::BK_ACC:
            begin
                if (acc_done)
                begin
                    state_next = cbpa_pkg::BK_AVG;
                end
            end
            cbpa_pkg::BK_AVG:
            begin
                if (avg_done)
                begin
                    state_next = cbpa_pkg::BK_EMIT;
                end
            end
            cbpa_pkg::BK_EMIT:  state_next = cbpa_pkg::BK_IDLE;
            default:            state_next = cbpa_pkg::BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_pop  = (state_reg == cbpa_pkg::BK_IDLE) && !cmd_empty && !res_full;
        res_push = (state_reg == cbpa_pkg::BK_EMIT);
        res_out.updated = (cmd_reg.kind != cbpa_pkg::CMD_REPEAT);
        if (cmd_reg.first)
        begin
            res_out.usage = '0;
        end
        else if (cmd_reg.kind == cbpa_pkg::CMD_COMPUTE)
        begin
            res_out.usage = tot_reg[cbpa_pkg::PCT_W-1:0];
        end
        else
        begin
            res_out.usage = last_usage_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cbpa_pkg::BK_IDLE;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            last_usage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop && (cmd_in.kind == cbpa_pkg::CMD_BASELINE))
            begin
                last_usage_reg <= '0;
            end
            if (state_reg == cbpa_pkg::BK_STORE)
            begin
                ptr_reg <= (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                if (fill_reg != FILL_W'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if ((state_reg == cbpa_pkg::BK_EMIT) && (cmd_reg.kind == cbpa_pkg::CMD_COMPUTE))
            begin
                last_usage_reg <= tot_reg[cbpa_pkg::PCT_W-1:0];
            end
        end
    end

    // Datapath. The percent divide forms 100 * |num| and then takes seven
    // quotient bits against |den| shifted down one place per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cbpa_pkg::BK_IDLE:
            begin
                if (cmd_pop)
                begin
                    cmd_reg <= cmd_in;
                end
            end
            cbpa_pkg::BK_SUM:
            begin
                sum_reg <= $signed({cmd_reg.du[cbpa_pkg::DELTA_W-1], cmd_reg.du})
                         + $signed({cmd_reg.dk[cbpa_pkg::DELTA_W-1], cmd_reg.dk});
            end
            cbpa_pkg::BK_NUM:
            begin
                num_reg <= $signed({sum_reg[cbpa_pkg::SUM_W-1], sum_reg})
                         - $signed({{2{cmd_reg.di[cbpa_pkg::DELTA_W-1]}}, cmd_reg.di});
            end
            cbpa_pkg::BK_ABS:
            begin
                an_reg <= num_reg[cbpa_pkg::NUM_W-1] ?
                          cbpa_pkg::NUM_W'(-num_reg) : cbpa_pkg::NUM_W'(num_reg);
                ad_reg <= sum_reg[cbpa_pkg::SUM_W-1] ?
                          cbpa_pkg::SUM_W'(-sum_reg) : cbpa_pkg::SUM_W'(sum_reg);
                trivial_reg <= (sum_reg == '0) || (num_reg == '0)
                            || (num_reg[cbpa_pkg::NUM_W-1] != sum_reg[cbpa_pkg::SUM_W-1]);
            end
            cbpa_pkg::BK_CLASS:
            begin
                pct_reg <= trivial_reg ? '0 : (saturate ? cbpa_pkg::PCT_FULL : '0);
            end
            cbpa_pkg::BK_MUL1:
            begin
                // Numerator is below the denominator here, so both fit in 64 bits.
                rem_reg <= {1'b0, an_reg[cbpa_pkg::MAG_W-1:0], 6'b0}
                         + {2'b0, an_reg[cbpa_pkg::MAG_W-1:0], 5'b0};
                dsh_reg <= {1'b0, ad_reg[cbpa_pkg::MAG_W-1:0], 6'b0};
                div_cnt_reg <= 3'(cbpa_pkg::QBITS - 1);
                pct_reg <= '0;
            end
            cbpa_pkg::BK_MUL2:
            begin
                rem_reg <= rem_reg + {5'b0, an_reg[cbpa_pkg::MAG_W-1:0], 2'b0};
            end
            cbpa_pkg::BK_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg     <= dsh_reg >> 1;
                pct_reg     <= {pct_reg[cbpa_pkg::PCT_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            cbpa_pkg::BK_STORE:
            begin
                ring_reg[ptr_reg] <= pct_reg;
                tot_reg     <= '0;
                idx_reg     <= '0;
                arem_reg    <= '0;
                avg_cnt_reg <= '0;
            end
            cbpa_pkg::BK_ACC:
            begin
                tot_reg <= tot_reg + TOT_W'(ring_reg[idx_reg]);
                idx_reg <= idx_reg + 1'b1;
            end
            cbpa_pkg::BK_AVG:
            begin
                // Restoring divide of the total by the fill count; the
                // quotient shifts in where the dividend shifts out.
                arem_reg    <= avg_ge ? FILL_W'(avg_trial - {1'b0, fill_reg})
                                      : FILL_W'(avg_trial);
                tot_reg     <= {tot_reg[TOT_W-2:0], avg_ge};
                avg_cnt_reg <= avg_cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbpa_pkg::BK_STORE) |-> (pct_reg <= cbpa_pkg::PCT_FULL))
        else $error("busy percent above full scale");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("ring fill count beyond window");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result beat pushed into a full queue");

    a_baseline_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cbpa_pkg::BK_EMIT) && (cmd_reg.kind == cbpa_pkg::CMD_BASELINE))
        |-> (last_usage_reg == '0))
        else $error("baseline sample did not clear the last usage");

endmodule

// ===== hw/rtl/cpu_busy_percent_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPU busy percent averager
// Averaged busy percentage from cumulative idle, kernel and user tick counters.
// ----------------------------------------------------------------------------
// Samples enter through a queue style port: a beat is taken when push is high
// and full is low. Each sample gives exactly one result beat, which waits on
// usage_percent and updated while empty is low and leaves when pop is high.
// The interval register is written through cfg_valid/cfg_ready/cfg_data and
// must only change while no sample is in flight.
// The front end decides at once whether a sample is taken and forwards the
// counter deltas through a two-entry command queue. The back end handles one
// sample at a time: a repeated or baseline sample goes straight to its result,
// while a computed one runs the seven-step percent divide, the ring summation
// and the serial divide of the total, skipping the multiply and the percent
// divide when the percent is plainly 0 or 100. Results are parked in a
// two-entry queue, so a stalled receiver only holds the back end once that
// queue is full, and full is then raised when the command queue fills behind
// it.
// Reset restores the interval to 200 ms and empties both queues and the ring.
// ----------------------------------------------------------------------------
module cpu_busy_percent_averager #(
    parameter int WINDOW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cbpa_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [cbpa_pkg::CNT_W-1:0]  idle_ticks,
    input  logic [cbpa_pkg::CNT_W-1:0]  kernel_ticks,
    input  logic [cbpa_pkg::CNT_W-1:0]  user_ticks,
    input  logic [cbpa_pkg::TIME_W-1:0] now_ms,
    output logic                        empty,
    input  logic                        pop,
    output logic [cbpa_pkg::PCT_W-1:0]  usage_percent,
    output logic                        updated
);

    cbpa_pkg::cmd_t    front_cmd;
    cbpa_pkg::cmd_t    back_cmd;
    cbpa_pkg::result_t back_res;
    cbpa_pkg::result_t out_res;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_push;
    logic              res_full;

    assign full          = cmd_full;
    assign usage_percent = out_res.usage;
    assign updated       = out_res.updated;

    cbpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .cmd_full     (cmd_full),
        .idle_ticks   (idle_ticks),
        .kernel_ticks (kernel_ticks),
        .user_ticks   (user_ticks),
        .now_ms       (now_ms),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    cbpa_fifo #(
        .WIDTH ($bits(cbpa_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    cbpa_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_in    (back_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_out   (back_res)
    );

    cbpa_fifo #(
        .WIDTH ($bits(cbpa_pkg::result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

endmodule
